// ===== rtl/core/assert_macros.svh =====
// assertion macros for the height map smoother rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define HMS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define HMS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HMS_ASSERT(label, clk, rst, prop, msg)
`define HMS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== rtl/core/hms_pkg.sv =====
// package with grid constants, types and address helper of the height map smoother
package hms_pkg;

  // grid geometry
  localparam int GRID_SIZE     = 16;
  localparam int COORD_W       = $clog2(GRID_SIZE);
  localparam int ADDR_W        = $clog2(GRID_SIZE * GRID_SIZE);

  // field widths
  localparam int OPCODE_W      = 2;
  localparam int FIELD_COORD_W = 4;
  localparam int HEIGHT_W      = 8;
  localparam int COUNT_W       = 8;

  // 3x3 sum and divide by nine through a reciprocal multiply
  localparam int SUM_W         = $clog2(9 * 255 + 1);
  localparam int RECIP9        = 7282;
  localparam int RECIP_W       = 13;
  localparam int MEAN_SHIFT    = 16;
  localparam int PROD_W        = SUM_W + RECIP_W;

  // reset value of the smoothing threshold
  localparam logic [HEIGHT_W-1:0] THRESH_RESET = HEIGHT_W'(2);

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_SMOOTH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_DATA,
    ST_SM_READ,
    ST_SM_LAST,
    ST_SM_MUL,
    ST_SM_APPLY,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                      opcode;
    logic [FIELD_COORD_W-1:0] cell_row;
    logic [FIELD_COORD_W-1:0] cell_col;
    logic [HEIGHT_W-1:0]      height_in;
  } cmd_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height_out;
    logic [COUNT_W-1:0]  changed_count;
  } result_t;

  // linear cell address, rows outer
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_SIZE) + ADDR_W'(c));
  endfunction

endpackage

// ===== rtl/core/hms_ram.sv =====
// simple dual port ram, one write and one registered read port
module hms_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hms_ctrl.sv =====
// sequencer for cell access and the in-place 3x3 smoothing walk over the height ram
`include "assert_macros.svh"
module hms_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  hms_pkg::cmd_t                cmd,
  input  logic [hms_pkg::HEIGHT_W-1:0] threshold,
  output logic                         res_valid,
  input  logic                         res_ready,
  output hms_pkg::result_t             res
);
  import hms_pkg::*;

  state_t               state, state_next;
  logic [COORD_W-1:0]   row, col;
  logic [1:0]           dr, dc;
  logic [SUM_W-1:0]     sum;
  logic [HEIGHT_W-1:0]  centre;
  logic [PROD_W-1:0]    prod;
  logic [COUNT_W-1:0]   count, count_next;
  logic                 rd_pend, ctr_pend, rd_inrange;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [HEIGHT_W-1:0]  ram_wdata, rd_data;

  logic                 cmd_fire, in_grid, last_cell, smooth_en;
  logic [ADDR_W-1:0]    cmd_addr;
  logic [COORD_W-1:0]   nb_row, nb_col;
  logic [HEIGHT_W-1:0]  mean, diff, new_h;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign res_valid = (state == ST_DONE);

  // addressed cell of an incoming command
  assign in_grid  = (int'(cmd.cell_row) < GRID_SIZE) && (int'(cmd.cell_col) < GRID_SIZE);
  assign cmd_addr = cell_addr(COORD_W'(cmd.cell_row), COORD_W'(cmd.cell_col));

  // neighbour of the current interior cell
  assign nb_row = COORD_W'(row + COORD_W'(dr) - COORD_W'(1));
  assign nb_col = COORD_W'(col + COORD_W'(dc) - COORD_W'(1));
  assign last_cell = (row == COORD_W'(GRID_SIZE - 2)) && (col == COORD_W'(GRID_SIZE - 2));

  // smoothing decision from the registered product
  assign mean      = prod[MEAN_SHIFT +: HEIGHT_W];
  assign diff      = (centre > mean) ? centre - mean : mean - centre;
  assign smooth_en = diff > threshold;
  assign new_h     = HEIGHT_W'((({1'b0, centre}) + ({1'b0, mean})) >> 1);
  assign count_next = (smooth_en && new_h != centre && count != '1) ?
                      COUNT_W'(count + 1'b1) : count;

  hms_ram #(
    .DATA_W (HEIGHT_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cell_addr(row, col);
    ram_wdata  = new_h;
    ram_re     = 1'b0;
    ram_raddr  = cell_addr(nb_row, nb_col);
    unique case (state)
      ST_IDLE: begin
        ram_waddr = cmd_addr;
        ram_wdata = cmd.height_in;
        ram_raddr = cmd_addr;
        if (cmd_fire) begin
          unique case (cmd.opcode)
            OP_WRITE:  ram_we = in_grid;
            OP_READ: begin
              ram_re     = in_grid;
              state_next = ST_RD_DATA;
            end
            OP_SMOOTH: state_next = ST_SM_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_DATA: state_next = ST_DONE;
      ST_SM_READ: begin
        ram_re = 1'b1;
        if (dr == 2'd2 && dc == 2'd2) begin
          state_next = ST_SM_LAST;
        end
      end
      ST_SM_LAST: state_next = ST_SM_MUL;
      ST_SM_MUL:  state_next = ST_SM_APPLY;
      ST_SM_APPLY: begin
        ram_we     = smooth_en;
        state_next = last_cell ? ST_DONE : ST_SM_READ;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend  <= 1'b0;
      ctr_pend <= 1'b0;
    end else begin
      rd_pend  <= (state == ST_SM_READ);
      ctr_pend <= (state == ST_SM_READ) && (dr == 2'd1) && (dc == 2'd1);
    end
  end

  // walk counters, accumulator and result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE || state == ST_SM_APPLY) begin
      sum <= '0;
    end else if (rd_pend) begin
      sum <= SUM_W'(sum + SUM_W'(rd_data));
    end
    if (ctr_pend) begin
      centre <= rd_data;
    end
    if (state == ST_SM_MUL) begin
      prod <= PROD_W'(sum * PROD_W'(RECIP9));
    end
    unique case (state)
      ST_IDLE: begin
        rd_inrange <= in_grid;
        row        <= COORD_W'(1);
        col        <= COORD_W'(1);
        dr         <= 2'd0;
        dc         <= 2'd0;
        count      <= '0;
      end
      ST_RD_DATA: begin
        res.height_out    <= rd_inrange ? rd_data : '0;
        res.changed_count <= '0;
      end
      ST_SM_READ: begin
        if (dc == 2'd2) begin
          dc <= 2'd0;
          dr <= dr + 2'd1;
        end else begin
          dc <= dc + 2'd1;
        end
      end
      ST_SM_APPLY: begin
        dr    <= 2'd0;
        dc    <= 2'd0;
        count <= count_next;
        if (col == COORD_W'(GRID_SIZE - 2)) begin
          col <= COORD_W'(1);
          row <= COORD_W'(row + 1'b1);
        end else begin
          col <= COORD_W'(col + 1'b1);
        end
        if (last_cell) begin
          res.height_out    <= '0;
          res.changed_count <= count_next;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencing checks
  `HMS_ASSERT(a_mul_after_last, clk, rst, state == ST_SM_MUL |-> $past(state) == ST_SM_LAST, "multiply step not preceded by last neighbour read")
  `HMS_ASSERT(a_apply_after_mul, clk, rst, state == ST_SM_APPLY |-> $past(state) == ST_SM_MUL, "apply step not preceded by multiply")
  `HMS_ASSERT(a_write_states, clk, rst, ram_we |-> (state == ST_IDLE || state == ST_SM_APPLY), "ram written outside a write transfer or apply step")
  `HMS_ASSERT(a_mean_fits, clk, rst, state == ST_SM_APPLY |-> (prod >> (MEAN_SHIFT + HEIGHT_W)) == '0, "mean of neighbourhood exceeds height range")

endmodule

// ===== rtl/core/height_map_smoother.sv =====
// top level of the height map smoother: stream ports, threshold register, result register
//
// Holds a 16 x 16 grid of 8-bit heights in one synchronous ram.
// Input stream s_*: tuser carries the opcode (write cell, smooth pass, read cell),
// tdata carries row, column and the height to write. Output stream m_*: tdata
// carries the height read and the count of cells changed by a smooth pass.
// Writes give no result; the next item can be taken in the cycle after the write.
// A read passes the ram read, the RD_DATA and DONE states and the output register before
// its result shows on m_tdata; the next item is taken once the result has left DONE.
// A smooth pass walks the 14 x 14 interior cells in place, each cell in nine ram reads,
// a step for the last read data, a multiply step and an apply and write step, and
// returns the changed count; no item is taken meanwhile.
// cfg_data writes the smoothing threshold; cfg_ready is always high.
// Reset sets the threshold to 2 and empties the result register; the ram is not
// cleared, so cells must be written before they are read or smoothed.
// When m_tready is low the result waits in its register; writes still pass, while a
// further read or smooth holds its own result, and takes no item, until the waiting result is taken.
module height_map_smoother (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cell_row [3:0], cell_col [7:4], height_in [15:8]
  input  logic [1:0]  s_tuser,   // opcode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // height_out [7:0], changed_count [15:8]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import hms_pkg::*;

  cmd_t                cmd;
  result_t             res;
  logic                res_valid, res_ready;
  logic [HEIGHT_W-1:0] threshold;
  logic [HEIGHT_W-1:0] out_height;
  logic [COUNT_W-1:0]  out_count;

  // unpack input transfer
  assign cmd.opcode    = op_t'(s_tuser);
  assign cmd.cell_row  = s_tdata[3:0];
  assign cmd.cell_col  = s_tdata[7:4];
  assign cmd.height_in = s_tdata[15:8];

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  hms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (cmd),
    .threshold (threshold),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_height <= res.height_out;
      out_count  <= res.changed_count;
    end
  end

  assign m_tdata = {out_count, out_height};

endmodule

// ===== bench/height_map_smoother_tb.sv =====
// testbench for the height map smoother: directed and random cell traffic checked against a grid model
module height_map_smoother_tb;
  import hms_pkg::*;

  localparam int CELL_COUNT     = GRID_SIZE * GRID_SIZE;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 40;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_ITEMS    = 50;
  localparam int REPORT_LIMIT   = 10;

  // opcode the block must ignore
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // grid fill patterns
  localparam logic [7:0] FILL_CHECKER = 8'd0;
  localparam logic [7:0] FILL_DIMPLE  = 8'd1;

  // square patch written by the dimple fill
  localparam int DIMPLE_LO = 3;
  localparam int DIMPLE_HI = 7;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_FILL,
    STEP_THRESH
  } step_kind_t;

  // one directed step; arg is the height, the fill pattern or the threshold
  typedef struct packed {
    step_kind_t                kind;
    logic [OPCODE_W-1:0]       opc;
    logic [FIELD_COORD_W-1:0]  row;
    logic [FIELD_COORD_W-1:0]  col;
    logic [HEIGHT_W-1:0]       arg;
    logic                      typed;
    result_t                   want;
  } dir_step_t;

  localparam int DIR_STEPS = 26;
  localparam dir_step_t DIRECTED [DIR_STEPS] = '{
    '{STEP_ITEM,   OP_WRITE,  4'd0,  4'd0,  8'h00, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_WRITE,  4'd15, 4'd15, 8'hFF, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_WRITE,  4'd0,  4'd15, 8'hAA, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_WRITE,  4'd15, 4'd0,  8'h55, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd0,  4'd0,  8'h00, 1'b1, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd15, 4'd15, 8'h00, 1'b1, '{8'hFF, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd0,  4'd15, 8'h00, 1'b1, '{8'hAA, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd15, 4'd0,  8'h00, 1'b1, '{8'h55, 8'd0}},
    // unused opcode must not store anything
    '{STEP_ITEM,   OP_UNUSED, 4'd15, 4'd15, 8'h00, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd15, 4'd15, 8'h00, 1'b1, '{8'hFF, 8'd0}},
    '{STEP_ITEM,   OP_WRITE,  4'd15, 4'd15, 8'h00, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd15, 4'd15, 8'h00, 1'b1, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_WRITE,  4'd8,  4'd7,  8'h80, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd8,  4'd7,  8'h00, 1'b1, '{8'h80, 8'd0}},
    // smooth a checkerboard with the reset threshold; borders stay put
    '{STEP_FILL,   OP_WRITE,  4'd0,  4'd0,  FILL_CHECKER, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_SMOOTH, 4'd0,  4'd0,  8'h00, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd0,  4'd0,  8'h00, 1'b1, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd15, 4'd0,  8'h00, 1'b1, '{8'hFF, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd1,  4'd1,  8'h00, 1'b0, '{8'h00, 8'd0}},
    // top threshold: nothing can change
    '{STEP_THRESH, OP_WRITE,  4'd0,  4'd0,  8'hFF, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_SMOOTH, 4'd0,  4'd0,  8'h00, 1'b1, '{8'h00, 8'd0}},
    // zero threshold on a flat patch with one dip: cells that qualify but keep value
    '{STEP_THRESH, OP_WRITE,  4'd0,  4'd0,  8'h00, 1'b0, '{8'h00, 8'd0}},
    '{STEP_FILL,   OP_WRITE,  4'd0,  4'd0,  FILL_DIMPLE, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_SMOOTH, 4'd0,  4'd0,  8'h00, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd5,  4'd5,  8'h00, 1'b0, '{8'h00, 8'd0}},
    '{STEP_ITEM,   OP_READ,   4'd5,  4'd6,  8'h00, 1'b0, '{8'h00, 8'd0}}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // cell_row [3:0], cell_col [7:4], height_in [15:8]
  logic [1:0]  s_tuser   = '0;   // opcode [1:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;          // height_out [7:0], changed_count [15:8]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = '0;

  // grid model and expected results
  logic [HEIGHT_W-1:0] grid_model [CELL_COUNT];
  logic [HEIGHT_W-1:0] threshold_model = THRESH_RESET;
  result_t             pending_results [$];

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  quiet_cycles   = 0;
  bit  no_idle        = 1'b0;

  height_map_smoother dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one in-place pass over the interior, returns the number of cells that changed
  function automatic int smooth_grid_model();
    int changed, r, c, dr, dc, sum, mean, centre, diff, next_h;
    changed = 0;
    for (r = 1; r < GRID_SIZE - 1; r++) begin
      for (c = 1; c < GRID_SIZE - 1; c++) begin
        sum = 0;
        for (dr = -1; dr <= 1; dr++)
          for (dc = -1; dc <= 1; dc++)
            sum += int'(grid_model[(r + dr) * GRID_SIZE + c + dc]);
        mean   = sum / 9;
        centre = int'(grid_model[r * GRID_SIZE + c]);
        diff   = (centre > mean) ? centre - mean : mean - centre;
        if (diff > int'(threshold_model)) begin
          next_h = (centre + mean) >> 1;
          if (next_h != centre && changed < 255)
            changed++;
          grid_model[r * GRID_SIZE + c] = HEIGHT_W'(next_h);
        end
      end
    end
    return changed;
  endfunction

  // effect of one accepted cell command on the grid model
  function automatic void predict_cell_op(input logic [OPCODE_W-1:0] opc,
                                          input logic [3:0] r, input logic [3:0] c,
                                          input logic [7:0] h,
                                          output bit has_res, output result_t res);
    int addr;
    addr    = int'(r) * GRID_SIZE + int'(c);
    has_res = 1'b0;
    res     = '0;
    case (opc)
      OP_WRITE: begin
        grid_model[addr] = h;
      end
      OP_SMOOTH: begin
        has_res           = 1'b1;
        res.changed_count = COUNT_W'(smooth_grid_model());
      end
      OP_READ: begin
        has_res        = 1'b1;
        res.height_out = grid_model[addr];
      end
      default: ;
    endcase
  endfunction

  // offer one item, wait for its transfer, then record what it should produce
  task automatic send_item(input logic [OPCODE_W-1:0] opc, input logic [3:0] r,
                           input logic [3:0] c, input logic [7:0] h,
                           input bit typed, input result_t want);
    bit      has_res;
    result_t predicted;
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = opc;
    s_tdata  = {h, c, r};
    do @(posedge clk); while (!s_tready);
    predict_cell_op(opc, r, c, h, has_res, predicted);
    if (has_res)
      pending_results.insert(pending_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // write the grid with a pattern: the whole grid, or a small patch around one dip
  task automatic load_grid(input logic [7:0] pattern);
    int r, c;
    logic [7:0] h;
    for (r = 0; r < GRID_SIZE; r++) begin
      for (c = 0; c < GRID_SIZE; c++) begin
        if (pattern == FILL_CHECKER) begin
          h = ((r + c) % 2 == 1) ? 8'hFF : 8'h00;
          send_item(OP_WRITE, 4'(r), 4'(c), h, 1'b0, '0);
        end else if (r >= DIMPLE_LO && r <= DIMPLE_HI &&
                     c >= DIMPLE_LO && c <= DIMPLE_HI) begin
          h = (r == 5 && c == 5) ? 8'd4 : 8'd6;
          send_item(OP_WRITE, 4'(r), 4'(c), h, 1'b0, '0);
        end
      end
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [7:0] value);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    threshold_model = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mismatch bookkeeping, only the first few are printed
  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("error: %s expected %0d got %0d", what, want, got);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin : result_ready
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held     = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready = no_idle || ($urandom_range(0, 99) >= 34);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, tdata", 0, int'(m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.height_out)
          report_mismatch("height_out", int'(want.height_out), int'(m_tdata[7:0]));
        if (m_tdata[15:8] !== want.changed_count)
          report_mismatch("changed_count", int'(want.changed_count), int'(m_tdata[15:8]));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int phase, n, pick;
    logic [OPCODE_W-1:0] opc;
    logic [3:0] r, c;
    logic [7:0] h, thresh;

    foreach (grid_model[i]) grid_model[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed steps
    for (int i = 0; i < DIR_STEPS; i++) begin
      case (DIRECTED[i].kind)
        STEP_ITEM:   send_item(DIRECTED[i].opc, DIRECTED[i].row, DIRECTED[i].col,
                               DIRECTED[i].arg, DIRECTED[i].typed, DIRECTED[i].want);
        STEP_FILL:   load_grid(DIRECTED[i].arg);
        STEP_THRESH: set_threshold(DIRECTED[i].arg);
        default: ;
      endcase
    end

    // random traffic in phases with different thresholds; phase 2 runs without gaps
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       thresh = 8'($urandom_range(0, 7));
        1:       thresh = 8'($urandom_range(0, 255));
        2:       thresh = 8'($urandom_range(0, 3));
        default: thresh = 8'd1;
      endcase
      set_threshold(thresh);
      no_idle = (phase == 2);
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        r    = 4'($urandom_range(0, 15));
        c    = 4'($urandom_range(0, 15));
        h    = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
          h = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if (pick < 4) begin
          opc = OP_UNUSED;
        end else begin
          n++;
          if (pick < 10)
            opc = OP_SMOOTH;
          else if (pick < 40)
            opc = OP_READ;
          else
            opc = OP_WRITE;
        end
        send_item(opc, r, c, h, 1'b0, '0);
      end
    end

    // drain and report
    no_idle = 1'b0;
    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
